// ===== design/sabo_pkg.sv =====
package sabo_pkg;

    localparam int unsigned FIELD_W         = 32;
    localparam int unsigned COORD_WIDTH_DEF = 32;
    localparam int unsigned EPS_W           = 33;
    localparam logic [EPS_W-1:0] EPS_RESET  = EPS_W'(1);

    // pipeline depth: diff, product, cross, decide, output
    localparam int unsigned NUM_STAGES      = 5;
    localparam int unsigned LANE_STAGES     = 4;

    typedef enum logic [1:0] {
        MODE_POINT_BOX = 2'd0,
        MODE_BOX_BOX   = 2'd1,
        MODE_SEG_SEG   = 2'd2,
        MODE_SEG_BOX   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REL_NONE          = 2'd0,
        REL_PENETRATING   = 2'd1,
        REL_A_CONTAINS_B  = 2'd2,
        REL_B_CONTAINS_A  = 2'd3
    } t_relation;

endpackage

// ===== design/sabo_if.sv =====
interface sabo_req_if import sabo_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [FIELD_W-1:0] a_x0;
    logic [FIELD_W-1:0] a_y0;
    logic [FIELD_W-1:0] a_x1;
    logic [FIELD_W-1:0] a_y1;
    logic [FIELD_W-1:0] b_x0;
    logic [FIELD_W-1:0] b_y0;
    logic [FIELD_W-1:0] b_x1;
    logic [FIELD_W-1:0] b_y1;

    modport source (
        output valid, mode, a_x0, a_y0, a_x1, a_y1, b_x0, b_y0, b_x1, b_y1,
        input  ready
    );
    modport sink (
        input  valid, mode, a_x0, a_y0, a_x1, a_y1, b_x0, b_y0, b_x1, b_y1,
        output ready
    );
endinterface

interface sabo_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] relation;

    modport source (output valid, relation, input ready);
    modport sink (input valid, relation, output ready);
endinterface

interface sabo_cfg_if import sabo_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [EPS_W-1:0] parallel_epsilon;

    modport source (output valid, parallel_epsilon, input ready);
    modport sink (input valid, parallel_epsilon, output ready);
endinterface

// ===== design/segment_and_box_overlap_classifier_top.sv =====
// 2D overlap classifier: point/box, box/box, segment/segment, segment/box.
// i_req: one query per request (mode, shape A and shape B corners or
//   endpoints, Q16.16). i_cfg: writes parallel_epsilon (Q1.32), always
//   ready; write it only while no query is in flight.
// o_rsp: one relation per query, in order (none, penetrating, A contains B,
//   B contains A).
// Throughput: one query per cycle, sustained while o_rsp.ready is high.
//   A result passes five register stages: vector differences, 33x33
//   products, cross products, range/threshold decisions, output register.
//   The multiplier stage sets the cycle.
// Segment/box runs the four box edges in four parallel lanes; lane 0 also
//   serves segment/segment.
// Each stage holds its item while the next is full, so a stalled receiver
//   fills the pipeline and i_req.ready drops only once all five stages are
//   occupied; bubbles are squeezed out.
// Reset clears all valid bits and sets parallel_epsilon to 1 (one LSB).
module segment_and_box_overlap_classifier_top import sabo_pkg::*; #(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    sabo_req_if.sink   i_req,
    sabo_cfg_if.sink   i_cfg,
    sabo_rsp_if.source o_rsp
);

    localparam int unsigned W = COORD_WIDTH;

    logic [EPS_W-1:0]     r_eps;
    logic [NUM_STAGES:1]  r_v;
    logic [NUM_STAGES+1:1] w_rdy;

    logic signed [W-1:0] w_ax0, w_ay0, w_ax1, w_ay1;
    logic signed [W-1:0] w_bx0, w_by0, w_bx1, w_by1;
    t_mode               w_mode;

    t_mode     r_mode    [1:NUM_STAGES];
    t_relation r_rel_box [1:LANE_STAGES];
    logic      r_inside  [1:LANE_STAGES];
    t_relation r_rel;

    t_relation n_rel_box;
    logic      n_inside;
    t_relation n_rel;

    logic                w_strict;
    logic signed [W-1:0] w_l0_p4y;
    logic [3:0]          w_hit;

    function automatic logic in_box(input logic signed [W-1:0] px,
                                    input logic signed [W-1:0] py,
                                    input logic signed [W-1:0] x0,
                                    input logic signed [W-1:0] y0,
                                    input logic signed [W-1:0] x1,
                                    input logic signed [W-1:0] y1);
        return (px >= x0) && (py >= y0) && (px <= x1) && (py <= y1);
    endfunction

    assign w_mode = t_mode'(i_req.mode);
    assign w_ax0  = i_req.a_x0[W-1:0];
    assign w_ay0  = i_req.a_y0[W-1:0];
    assign w_ax1  = i_req.a_x1[W-1:0];
    assign w_ay1  = i_req.a_y1[W-1:0];
    assign w_bx0  = i_req.b_x0[W-1:0];
    assign w_by0  = i_req.b_y0[W-1:0];
    assign w_bx1  = i_req.b_x1[W-1:0];
    assign w_by1  = i_req.b_y1[W-1:0];

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_RESET;
        end else if (i_cfg.valid) begin
            r_eps <= i_cfg.parallel_epsilon;
        end
    end

    // per-stage flow control
    always_comb begin
        w_rdy[NUM_STAGES+1] = o_rsp.ready;
        for (int k = NUM_STAGES; k >= 1; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign i_req.ready = w_rdy[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[1]) begin
                r_v[1] <= i_req.valid;
            end
            for (int k = 2; k <= NUM_STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 1: box comparisons
    always_comb begin
        logic ovl_x;
        logic ovl_y;
        ovl_x     = (w_ax0 <= w_bx1) && (w_ax1 >= w_bx0);
        ovl_y     = (w_ay0 <= w_by1) && (w_ay1 >= w_by0);
        n_inside  = in_box(w_ax0, w_ay0, w_bx0, w_by0, w_bx1, w_by1) &&
                    in_box(w_ax1, w_ay1, w_bx0, w_by0, w_bx1, w_by1);
        n_rel_box = REL_NONE;
        unique case (w_mode) inside
            MODE_POINT_BOX: begin
                if (in_box(w_ax0, w_ay0, w_bx0, w_by0, w_bx1, w_by1)) begin
                    n_rel_box = REL_B_CONTAINS_A;
                end
            end
            MODE_BOX_BOX: begin
                // A containing B wins over B containing A for equal boxes
                if (ovl_x && ovl_y) begin
                    if (w_ax0 <= w_bx0 && w_ax1 >= w_bx1 &&
                        w_ay0 <= w_by0 && w_ay1 >= w_by1) begin
                        n_rel_box = REL_A_CONTAINS_B;
                    end else if (w_bx0 <= w_ax0 && w_bx1 >= w_ax1 &&
                                 w_by0 <= w_ay0 && w_by1 >= w_ay1) begin
                        n_rel_box = REL_B_CONTAINS_A;
                    end else begin
                        n_rel_box = REL_PENETRATING;
                    end
                end
            end
            MODE_SEG_SEG, MODE_SEG_BOX: begin
                n_rel_box = REL_NONE;
            end
            default: n_rel_box = REL_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_mode[1]    <= w_mode;
            r_rel_box[1] <= n_rel_box;
            r_inside[1]  <= n_inside;
        end
        for (int k = 2; k <= LANE_STAGES; k++) begin
            if (w_rdy[k]) begin
                r_mode[k]    <= r_mode[k-1];
                r_rel_box[k] <= r_rel_box[k-1];
                r_inside[k]  <= r_inside[k-1];
            end
        end
        if (w_rdy[NUM_STAGES]) begin
            r_mode[NUM_STAGES] <= r_mode[LANE_STAGES];
            r_rel              <= n_rel;
        end
    end

    // lane 0: segment B in mode 2, bottom edge in mode 3
    assign w_strict = (w_mode == MODE_SEG_SEG);
    assign w_l0_p4y = w_strict ? w_by1 : w_by0;

    sabo_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_bottom (
        .i_clk(i_clk), .i_en(w_rdy[LANE_STAGES:1]), .i_strict(w_strict), .i_eps(r_eps),
        .i_p1x(w_ax0), .i_p1y(w_ay0), .i_p2x(w_ax1), .i_p2y(w_ay1),
        .i_p3x(w_bx0), .i_p3y(w_by0), .i_p4x(w_bx1), .i_p4y(w_l0_p4y),
        .o_hit(w_hit[0])
    );

    sabo_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_right (
        .i_clk(i_clk), .i_en(w_rdy[LANE_STAGES:1]), .i_strict(1'b0), .i_eps(r_eps),
        .i_p1x(w_ax0), .i_p1y(w_ay0), .i_p2x(w_ax1), .i_p2y(w_ay1),
        .i_p3x(w_bx1), .i_p3y(w_by0), .i_p4x(w_bx1), .i_p4y(w_by1),
        .o_hit(w_hit[1])
    );

    sabo_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_top (
        .i_clk(i_clk), .i_en(w_rdy[LANE_STAGES:1]), .i_strict(1'b0), .i_eps(r_eps),
        .i_p1x(w_ax0), .i_p1y(w_ay0), .i_p2x(w_ax1), .i_p2y(w_ay1),
        .i_p3x(w_bx1), .i_p3y(w_by1), .i_p4x(w_bx0), .i_p4y(w_by1),
        .o_hit(w_hit[2])
    );

    sabo_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_left (
        .i_clk(i_clk), .i_en(w_rdy[LANE_STAGES:1]), .i_strict(1'b0), .i_eps(r_eps),
        .i_p1x(w_ax0), .i_p1y(w_ay0), .i_p2x(w_ax1), .i_p2y(w_ay1),
        .i_p3x(w_bx0), .i_p3y(w_by1), .i_p4x(w_bx0), .i_p4y(w_by0),
        .o_hit(w_hit[3])
    );

    // stage 5: final selection
    always_comb begin
        n_rel = REL_NONE;
        unique case (r_mode[LANE_STAGES]) inside
            MODE_POINT_BOX, MODE_BOX_BOX: begin
                n_rel = r_rel_box[LANE_STAGES];
            end
            MODE_SEG_SEG: begin
                n_rel = w_hit[0] ? REL_PENETRATING : REL_NONE;
            end
            MODE_SEG_BOX: begin
                if (r_inside[LANE_STAGES]) begin
                    n_rel = REL_B_CONTAINS_A;
                end else if (|w_hit) begin
                    n_rel = REL_PENETRATING;
                end
            end
            default: n_rel = REL_NONE;
        endcase
    end

    assign o_rsp.valid    = r_v[NUM_STAGES];
    assign o_rsp.relation = r_rel;

    // input side stalls only with every stage occupied
    a_full_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (&r_v))
        else $error("request refused while the pipeline has a free stage");

    // containment of B by A can only come from the box/box test
    a_a_contains_b_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.relation == REL_A_CONTAINS_B) |->
            (r_mode[NUM_STAGES] == MODE_BOX_BOX))
        else $error("A-contains-B result outside box/box mode");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp.valid)
        else $error("result valid straight after reset");

endmodule

// ===== design/sabo_lane.sv =====
module sabo_lane import sabo_pkg::*; #(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic [LANE_STAGES-1:0]        i_en,
    input  logic                          i_strict,
    input  logic [EPS_W-1:0]              i_eps,
    input  logic signed [COORD_WIDTH-1:0] i_p1x,
    input  logic signed [COORD_WIDTH-1:0] i_p1y,
    input  logic signed [COORD_WIDTH-1:0] i_p2x,
    input  logic signed [COORD_WIDTH-1:0] i_p2y,
    input  logic signed [COORD_WIDTH-1:0] i_p3x,
    input  logic signed [COORD_WIDTH-1:0] i_p3y,
    input  logic signed [COORD_WIDTH-1:0] i_p4x,
    input  logic signed [COORD_WIDTH-1:0] i_p4y,
    output logic                          o_hit
);

    localparam int unsigned DW = COORD_WIDTH + 1;
    localparam int unsigned PW = 2 * DW;
    localparam int unsigned CW = PW + 1;
    localparam int unsigned XW = (CW > EPS_W) ? CW : EPS_W;

    // stage 1: direction and offset vectors
    logic signed [DW-1:0] r_d1x, r_d1y, r_d2x, r_d2y, r_ox, r_oy;
    // stage 2: partial products
    logic signed [PW-1:0] r_m_d1x_d2y, r_m_d1y_d2x;
    logic signed [PW-1:0] r_m_ox_d2y, r_m_oy_d2x;
    logic signed [PW-1:0] r_m_ox_d1y, r_m_oy_d1x;
    // stage 3: cross products
    logic signed [CW-1:0] r_den, r_num_a, r_num_b;
    logic                 r_strict [1:3];
    logic                 n_hit;

    function automatic logic t_in_unit(input logic signed [CW-1:0] num,
                                       input logic signed [CW-1:0] den);
        logic res;
        if (den == '0) begin
            res = 1'b0;
        end else if (!den[CW-1]) begin
            res = (num >= 0) && (num <= den);
        end else begin
            res = (num <= 0) && (num >= den);
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_d1x       <= DW'(i_p2x) - DW'(i_p1x);
            r_d1y       <= DW'(i_p2y) - DW'(i_p1y);
            r_d2x       <= DW'(i_p4x) - DW'(i_p3x);
            r_d2y       <= DW'(i_p4y) - DW'(i_p3y);
            r_ox        <= DW'(i_p3x) - DW'(i_p1x);
            r_oy        <= DW'(i_p3y) - DW'(i_p1y);
            r_strict[1] <= i_strict;
        end
        if (i_en[1]) begin
            r_m_d1x_d2y <= PW'(r_d1x) * PW'(r_d2y);
            r_m_d1y_d2x <= PW'(r_d1y) * PW'(r_d2x);
            r_m_ox_d2y  <= PW'(r_ox) * PW'(r_d2y);
            r_m_oy_d2x  <= PW'(r_oy) * PW'(r_d2x);
            r_m_ox_d1y  <= PW'(r_ox) * PW'(r_d1y);
            r_m_oy_d1x  <= PW'(r_oy) * PW'(r_d1x);
            r_strict[2] <= r_strict[1];
        end
        if (i_en[2]) begin
            r_den       <= CW'(r_m_d1x_d2y) - CW'(r_m_d1y_d2x);
            r_num_a     <= CW'(r_m_ox_d2y) - CW'(r_m_oy_d2x);
            r_num_b     <= CW'(r_m_ox_d1y) - CW'(r_m_oy_d1x);
            r_strict[3] <= r_strict[2];
        end
        if (i_en[3]) begin
            o_hit <= n_hit;
        end
    end

    always_comb begin
        logic [CW-1:0] abs_den;
        logic [XW-1:0] abs_x;
        logic [XW-1:0] eps_x;
        logic          parallel;
        abs_den  = r_den[CW-1] ? CW'(-r_den) : CW'(r_den);
        abs_x    = XW'(abs_den);
        eps_x    = XW'(i_eps);
        // mode 2 uses a strict threshold, box edges an inclusive one
        parallel = r_strict[3] ? (abs_x < eps_x) : (abs_x <= eps_x);
        n_hit    = !parallel && t_in_unit(r_num_a, r_den) && t_in_unit(r_num_b, r_den);
    end

endmodule
